// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define PCF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define PCF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pcf_pkg.sv
// constants, register codes and saturation helper for the contact force block
// no dependencies
`default_nettype none

package pcf_pkg;

	localparam int DATA_W      = 32;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 31;
	localparam int IN_TDATA_W  = 256;
	localparam int OUT_TDATA_W = 96;

	localparam logic [CFG_ADDR_W-1:0] CFG_STIFFNESS = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DAMPING   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRICTION  = 2'd2;

	localparam logic [30:0] STIFFNESS_RST = 31'd65536;
	localparam logic [30:0] DAMPING_RST   = 31'd0;
	localparam logic [18:0] FRICTION_RST  = 19'd0;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	// clamp a wide signed value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return SAT_MAX;
		if (x < -66'sd2147483648) return SAT_MIN;
		return x[31:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/particle_contact_force.sv
// sphere pair contact force: spring-dashpot normal force plus coulomb friction
// depends on pcf_pkg
// data is fixed point with FRAC_BITS fraction bits (Q16.16 at the default); it takes one word
// per cycle unless the output stalls, and the pipe is mostly two 32-step square root pipes,
// a FRAC_BITS+1 step normal divider and a 31 step friction divider, one bit per stage
// a stalled output word freezes the whole pipe, nothing is dropped or repeated
// reset (arst_n low) clears all valid bits and loads the register reset values
`default_nettype none

module particle_contact_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [pcf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input words
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// offset_x, offset_y, offset_z, rel_vel_x, rel_vel_y, rel_vel_z, radius_a, radius_b
	input  logic [pcf_pkg::IN_TDATA_W-1:0]    s_tdata,
	// result words
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// force_x, force_y, force_z
	output logic [pcf_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// in_contact
	output logic [0:0]                        m_tuser
);

	localparam int F   = FRAC_BITS;
	localparam int NW  = F + 2;      // signed unit normal, magnitude up to one
	localparam int QW  = F + 1;      // normal quotient bits
	localparam int R1  = F + 33;     // normal divider remainder
	localparam int LAT = 108 + F;    // total register stages
	localparam logic signed [NW-1:0] N_ONE = NW'(1) << F;

	// sqrt pipe for distance, carries the raw operands along
	typedef struct packed {
		logic [63:0]      rem;
		logic [31:0]      root;
		logic [2:0][31:0] d;
		logic [2:0][31:0] v;
		logic [31:0]      rsum;
	} rt1_t;

	// divider pipe for the unit normal
	typedef struct packed {
		logic [2:0][R1-1:0] rem;
		logic [2:0][QW-1:0] q;
		logic [2:0]         neg;
		logic [31:0]        den;
		logic               zdist;
		logic               contact;
		logic [31:0]        ovl;
		logic [2:0][31:0]   v;
	} dv1_t;

	// sqrt pipe for tangential speed
	typedef struct packed {
		logic [63:0]      rem;
		logic [31:0]      root;
		logic [2:0][31:0] t;
		logic [30:0]      fm;
		logic [2:0][32:0] nfp;
		logic             contact;
	} rt2_t;

	// divider pipe for friction components
	typedef struct packed {
		logic [2:0][63:0] rem;
		logic [2:0][30:0] q;
		logic [2:0]       neg;
		logic [31:0]      ts;
		logic             tsz;
		logic [2:0][32:0] nfp;
		logic             contact;
	} dv2_t;

	logic [30:0] stiff_q;
	logic [30:0] damp_q;
	logic [18:0] fric_q;
	logic [LAT-1:0] vld_q;
	logic en;

	// whole pipe moves unless the output word is held
	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= pcf_pkg::STIFFNESS_RST;
			damp_q  <= pcf_pkg::DAMPING_RST;
			fric_q  <= pcf_pkg::FRICTION_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pcf_pkg::CFG_STIFFNESS: stiff_q <= cfg_wdata;
				pcf_pkg::CFG_DAMPING:   damp_q  <= cfg_wdata;
				pcf_pkg::CFG_FRICTION:  fric_q  <= cfg_wdata[18:0];
				default: ;
			endcase
		end
	end

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// ---------------- stage 1: unpack and square the offsets ----------------
	logic signed [31:0] in_d [3];
	logic signed [31:0] in_v [3];
	logic signed [63:0] sq_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_d[i] = s_tdata[32*i +: 32];
			in_v[i] = s_tdata[96+32*i +: 32];
			sq_c[i] = in_d[i] * in_d[i];
		end
	end

	logic signed [31:0] d_s1 [3];
	logic signed [31:0] v_s1 [3];
	logic [63:0]        sq_s1 [3];
	logic [31:0]        rsum_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= in_d[i];
				v_s1[i]  <= in_v[i];
				sq_s1[i] <= sq_c[i];
			end
			rsum_s1 <= {1'b0, s_tdata[222:192]} + {1'b0, s_tdata[253:223]};
		end
	end

	// ---------------- stage 2 and distance square root ----------------
	rt1_t rt1_s [0:32];

	always_ff @(posedge clk) begin
		if (en) begin
			rt1_s[0].rem  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			rt1_s[0].root <= '0;
			rt1_s[0].rsum <= rsum_s1;
			for (int i = 0; i < 3; i++) begin
				rt1_s[0].d[i] <= d_s1[i];
				rt1_s[0].v[i] <= v_s1[i];
			end
		end
	end

	// one root bit per stage, remainder kept as x - root^2
	for (genvar gi = 0; gi < 32; gi++) begin : g_sqrt_dist
		localparam int J = 31 - gi;
		logic [65:0] term;
		logic        take;
		rt1_t        nxt;
		assign term = ({34'd0, rt1_s[gi].root} << (J + 1)) | (66'd1 << (2 * J));
		assign take = {2'b00, rt1_s[gi].rem} >= term;
		always_comb begin
			nxt = rt1_s[gi];
			if (take) begin
				nxt.rem  = rt1_s[gi].rem - term[63:0];
				nxt.root = rt1_s[gi].root | (32'd1 << J);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt1_s[gi+1] <= nxt;
			end
		end
	end

	// ---------------- overlap and normal division ----------------
	logic [31:0]        dist_c;
	logic signed [33:0] ov_c;
	logic [31:0]        dmag_c [3];

	always_comb begin
		dist_c = rt1_s[32].root;
		ov_c   = $signed({2'b00, rt1_s[32].rsum}) - $signed({2'b00, dist_c});
		for (int i = 0; i < 3; i++) begin
			dmag_c[i] = rt1_s[32].d[i][31] ? 32'd0 - rt1_s[32].d[i] : rt1_s[32].d[i];
		end
	end

	dv1_t dv1_s [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv1_s[0].rem[i] <= R1'(dmag_c[i]) << F;
				dv1_s[0].q[i]   <= '0;
				dv1_s[0].neg[i] <= rt1_s[32].d[i][31];
				dv1_s[0].v[i]   <= rt1_s[32].v[i];
			end
			dv1_s[0].den     <= dist_c;
			dv1_s[0].zdist   <= (dist_c == 32'd0);
			dv1_s[0].contact <= !ov_c[33] && (ov_c != 34'd0);
			dv1_s[0].ovl     <= pcf_pkg::sat32(66'(ov_c));
		end
	end

	// restoring division, |offset| <= distance keeps the quotient within QW bits
	for (genvar gi = 0; gi < QW; gi++) begin : g_div_norm
		localparam int K = F - gi;
		logic [R1-1:0] dsh;
		logic [2:0]    take;
		dv1_t          nxt;
		assign dsh = R1'(dv1_s[gi].den) << K;
		always_comb begin
			nxt = dv1_s[gi];
			for (int i = 0; i < 3; i++) begin
				take[i] = dv1_s[gi].rem[i] >= dsh;
				if (take[i]) begin
					nxt.rem[i] = dv1_s[gi].rem[i] - dsh;
					nxt.q[i]   = dv1_s[gi].q[i] | (QW'(1) << K);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv1_s[gi+1] <= nxt;
			end
		end
	end

	// ---------------- stage 3: signed unit normal ----------------
	logic signed [NW-1:0] n_s3 [3];
	logic signed [31:0]   v_s3 [3];
	logic signed [31:0]   ovl_s3;
	logic                 contact_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv1_s[QW].zdist) begin
					// coincident centers: normal along x
					n_s3[i] <= (i == 0) ? N_ONE : '0;
				end else if (dv1_s[QW].neg[i]) begin
					n_s3[i] <= NW'(0) - NW'(dv1_s[QW].q[i]);
				end else begin
					n_s3[i] <= NW'(dv1_s[QW].q[i]);
				end
				v_s3[i] <= dv1_s[QW].v[i];
			end
			ovl_s3     <= dv1_s[QW].ovl;
			contact_s3 <= dv1_s[QW].contact;
		end
	end

	// ---------------- stage 4: velocity times normal ----------------
	logic signed [NW+31:0] pv_c [3];
	logic signed [NW+31:0] pv_s4 [3];
	logic signed [NW-1:0]  n_s4 [3];
	logic signed [31:0]    v_s4 [3];
	logic signed [31:0]    ovl_s4;
	logic                  contact_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pv_c[i] = n_s3[i] * v_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pv_s4[i] <= pv_c[i];
				n_s4[i]  <= n_s3[i];
				v_s4[i]  <= v_s3[i];
			end
			ovl_s4     <= ovl_s3;
			contact_s4 <= contact_s3;
		end
	end

	// ---------------- stage 5: normal speed ----------------
	logic signed [NW+33:0] vsum_c;
	logic signed [NW+33:0] vsh_c;
	logic signed [31:0]    vn_s5;
	logic signed [NW-1:0]  n_s5 [3];
	logic signed [31:0]    v_s5 [3];
	logic signed [31:0]    ovl_s5;
	logic                  contact_s5;

	assign vsum_c = (NW+34)'(pv_s4[0]) + (NW+34)'(pv_s4[1]) + (NW+34)'(pv_s4[2]);
	assign vsh_c  = vsum_c >>> F;

	always_ff @(posedge clk) begin
		if (en) begin
			vn_s5 <= pcf_pkg::sat32(66'(vsh_c));
			for (int i = 0; i < 3; i++) begin
				n_s5[i] <= n_s4[i];
				v_s5[i] <= v_s4[i];
			end
			ovl_s5     <= ovl_s4;
			contact_s5 <= contact_s4;
		end
	end

	// ---------------- stage 6: spring, dashpot and normal velocity terms ----------------
	logic signed [63:0]    ks_c;
	logic signed [63:0]    kd_c;
	logic signed [NW+31:0] nv_c [3];
	logic signed [63:0]    ks_s6;
	logic signed [63:0]    kd_s6;
	logic signed [NW+31:0] nv_s6 [3];
	logic signed [NW-1:0]  n_s6 [3];
	logic signed [31:0]    v_s6 [3];
	logic                  contact_s6;

	always_comb begin
		ks_c = $signed({1'b0, stiff_q}) * ovl_s5;
		kd_c = $signed({1'b0, damp_q}) * vn_s5;
		for (int i = 0; i < 3; i++) begin
			nv_c[i] = n_s5[i] * vn_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ks_s6 <= ks_c;
			kd_s6 <= kd_c;
			for (int i = 0; i < 3; i++) begin
				nv_s6[i] <= nv_c[i];
				n_s6[i]  <= n_s5[i];
				v_s6[i]  <= v_s5[i];
			end
			contact_s6 <= contact_s5;
		end
	end

	// ---------------- stage 7: normal force and tangential velocity ----------------
	logic signed [64:0] fa_c;
	logic signed [64:0] fs_c;
	logic [30:0]        fn_c;
	logic signed [65:0] tw_c [3];
	logic [30:0]        fn_s7;
	logic signed [31:0] t_s7 [3];
	logic signed [NW-1:0] n_s7 [3];
	logic               contact_s7;

	always_comb begin
		fa_c = 65'(ks_s6) + 65'(kd_s6);
		fs_c = fa_c >>> F;
		// clamp to [0, 2^31-1]
		if (fs_c[64]) begin
			fn_c = '0;
		end else if (fs_c > 65'sd2147483647) begin
			fn_c = '1;
		end else begin
			fn_c = fs_c[30:0];
		end
		for (int i = 0; i < 3; i++) begin
			tw_c[i] = 66'(v_s6[i]) - 66'(nv_s6[i] >>> F);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s7 <= fn_c;
			for (int i = 0; i < 3; i++) begin
				t_s7[i] <= pcf_pkg::sat32(tw_c[i]);
				n_s7[i] <= n_s6[i];
			end
			contact_s7 <= contact_s6;
		end
	end

	// ---------------- stage 8: tangential squares, friction magnitude, normal force ----------------
	logic signed [63:0]    tsq_c [3];
	logic [49:0]           fmp_c;
	logic signed [NW+31:0] nfn_c [3];
	logic [63:0]           tsq_s8 [3];
	logic [49:0]           fmp_s8;
	logic signed [NW+31:0] nfn_s8 [3];
	logic signed [31:0]    t_s8 [3];
	logic                  contact_s8;

	always_comb begin
		fmp_c = fric_q * fn_s7;
		for (int i = 0; i < 3; i++) begin
			tsq_c[i] = t_s7[i] * t_s7[i];
			nfn_c[i] = n_s7[i] * $signed({1'b0, fn_s7});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmp_s8 <= fmp_c;
			for (int i = 0; i < 3; i++) begin
				tsq_s8[i] <= tsq_c[i];
				nfn_s8[i] <= nfn_c[i];
				t_s8[i]   <= t_s7[i];
			end
			contact_s8 <= contact_s7;
		end
	end

	// ---------------- stage 9 and tangential speed square root ----------------
	logic [49:0]           fmsh_c;
	logic signed [NW+31:0] nfsh_c [3];
	rt2_t rt2_s [0:32];

	always_comb begin
		fmsh_c = fmp_s8 >> F;
		for (int i = 0; i < 3; i++) begin
			nfsh_c[i] = nfn_s8[i] >>> F;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt2_s[0].rem  <= tsq_s8[0] + tsq_s8[1] + tsq_s8[2];
			rt2_s[0].root <= '0;
			rt2_s[0].fm   <= (fmsh_c > 50'd2147483647) ? 31'h7fffffff : fmsh_c[30:0];
			for (int i = 0; i < 3; i++) begin
				rt2_s[0].t[i]   <= t_s8[i];
				rt2_s[0].nfp[i] <= nfsh_c[i][32:0];
			end
			rt2_s[0].contact <= contact_s8;
		end
	end

	for (genvar gi = 0; gi < 32; gi++) begin : g_sqrt_tang
		localparam int J = 31 - gi;
		logic [65:0] term;
		logic        take;
		rt2_t        nxt;
		assign term = ({34'd0, rt2_s[gi].root} << (J + 1)) | (66'd1 << (2 * J));
		assign take = {2'b00, rt2_s[gi].rem} >= term;
		always_comb begin
			nxt = rt2_s[gi];
			if (take) begin
				nxt.rem  = rt2_s[gi].rem - term[63:0];
				nxt.root = rt2_s[gi].root | (32'd1 << J);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt2_s[gi+1] <= nxt;
			end
		end
	end

	// ---------------- stage 10 and friction division ----------------
	logic [31:0] tmag_c [3];
	logic [63:0] tp_c [3];
	dv2_t dv2_s [0:31];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tmag_c[i] = rt2_s[32].t[i][31] ? 32'd0 - rt2_s[32].t[i] : rt2_s[32].t[i];
			tp_c[i]   = tmag_c[i] * rt2_s[32].fm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv2_s[0].rem[i] <= tp_c[i];
				dv2_s[0].q[i]   <= '0;
				dv2_s[0].neg[i] <= rt2_s[32].t[i][31];
				dv2_s[0].nfp[i] <= rt2_s[32].nfp[i];
			end
			dv2_s[0].ts      <= rt2_s[32].root;
			dv2_s[0].tsz     <= (rt2_s[32].root == 32'd0);
			dv2_s[0].contact <= rt2_s[32].contact;
		end
	end

	// |t| <= ts so the quotient never exceeds the friction magnitude
	for (genvar gi = 0; gi < 31; gi++) begin : g_div_fric
		localparam int K = 30 - gi;
		logic [63:0] dsh;
		logic [2:0]  take;
		dv2_t        nxt;
		assign dsh = 64'(dv2_s[gi].ts) << K;
		always_comb begin
			nxt = dv2_s[gi];
			for (int i = 0; i < 3; i++) begin
				take[i] = dv2_s[gi].rem[i] >= dsh;
				if (take[i]) begin
					nxt.rem[i] = dv2_s[gi].rem[i] - dsh;
					nxt.q[i]   = dv2_s[gi].q[i] | (31'd1 << K);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv2_s[gi+1] <= nxt;
			end
		end
	end

	// ---------------- stage 11: combine, saturate, output register ----------------
	logic signed [31:0] fric_c [3];
	logic signed [65:0] fd_c [3];
	logic signed [31:0] force_s11 [3];
	logic               contact_s11;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv2_s[31].tsz) begin
				// no tangential motion, no friction
				fric_c[i] = '0;
			end else if (dv2_s[31].neg[i]) begin
				fric_c[i] = 32'd0 - {1'b0, dv2_s[31].q[i]};
			end else begin
				fric_c[i] = {1'b0, dv2_s[31].q[i]};
			end
			fd_c[i] = 66'(fric_c[i]) - 66'($signed(dv2_s[31].nfp[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				force_s11[i] <= dv2_s[31].contact ? pcf_pkg::sat32(fd_c[i]) : '0;
			end
			contact_s11 <= dv2_s[31].contact;
		end
	end

	assign m_tdata = {force_s11[2], force_s11[1], force_s11[0]};
	assign m_tuser = contact_s11;

endmodule

`default_nettype wire

// File: rtl/pcf_checker.sv
// port-level checks for the contact force block, bound to the top level
// depends on pcf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pcf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [pcf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [0:0]                      m_tuser
);

	// a word without contact carries zero force
	`PCF_ASSERT_IMPL(a_no_contact_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "force nonzero without contact")

	// input side opens exactly when the output word moves or is empty
	`PCF_ASSERT_IMPL(a_ready_follows_out, clk, arst_n, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready), "input ready does not track output")

	// a held result word keeps its value
	`PCF_ASSERT_NEXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")

endmodule

bind particle_contact_force pcf_checker u_pcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
